### rtl/tlsp_pkg.sv
package tlsp_pkg;

   localparam int MAX_NODES_DEF = 32;
   localparam int MAX_EDGES_DEF = 256;
   localparam int COST_BITS_DEF = 16;

   localparam int NODE_FIELD_W = 5;
   localparam int COST_FIELD_W = 16;
   localparam int DIST_W       = 24;
   localparam int COUNT_W      = 6;

   localparam logic [DIST_W-1:0]  DIST_MAX    = {DIST_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

   typedef enum logic [1:0] {
      KIND_CLEAR   = 2'd0,
      KIND_NORMAL  = 2'd1,
      KIND_EXPRESS = 2'd2,
      KIND_QUERY   = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD2,
      ST_SCAN,
      ST_SCAN_TAIL,
      ST_POP,
      ST_EDGE_RD,
      ST_EDGE_CHK,
      ST_RELAX,
      ST_PICK_A,
      ST_PICK_B,
      ST_PICK_C,
      ST_WALK_RD,
      ST_WALK_EMIT,
      ST_UNREACH
   } state_type;

   typedef struct packed {
      kind_type                 kind;
      logic [NODE_FIELD_W-1:0]  node_a;
      logic [NODE_FIELD_W-1:0]  node_b;
      logic [COST_FIELD_W-1:0]  edge_cost;
   } req_word_type;

   typedef struct packed {
      logic [NODE_FIELD_W-1:0]  path_node;
      logic                     last_item;
      logic                     ticket_used;
      logic [NODE_FIELD_W-1:0]  ticket_node;
      logic [DIST_W-1:0]        total_cost;
      logic                     unreachable;
   } rsp_word_type;

endpackage

### rtl/tlsp_ram.sv
module tlsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/two_layer_shortest_path_one_ticket_unit.sv
// Shortest path with one express ticket. Edge words build per-node adjacency
// lists in an edge memory (two entries per edge, newest first); a query word
// runs Dijkstra over two layers per node, with distances and parents in a
// state memory of one read port. A clear empties every list and an edge add
// writes its two entries in turn. For every state popped, a query scans the
// state memory for the cheapest queued state, pops it and then reads and
// relaxes each adjacency entry; a last scan finds the queue empty, then the
// target layer is picked and one word goes out per path node emitted, held
// under stall. Results leave target first; the last word carries cost and
// ticket data.
module two_layer_shortest_path_one_ticket_unit #(
   parameter int MAX_NODES = tlsp_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES = tlsp_pkg::MAX_EDGES_DEF,
   parameter int COST_BITS = tlsp_pkg::COST_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tlsp_pkg::req_word_type         req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tlsp_pkg::rsp_word_type         rsp_word,
   input  logic                           csr_we,
   input  logic [tlsp_pkg::COUNT_W-1:0]   csr_wdata
);

   localparam int NF       = tlsp_pkg::NODE_FIELD_W;
   localparam int DW       = tlsp_pkg::DIST_W;
   localparam int CW       = tlsp_pkg::COUNT_W;
   localparam int NODE_W   = $clog2(MAX_NODES);
   localparam int STATE_W  = NODE_W + 1;
   localparam int NSTATES  = 2 * MAX_NODES;
   localparam int NENTRIES = 2 * MAX_EDGES;
   localparam int ENTRY_W  = $clog2(NENTRIES);
   localparam int TOTAL_W  = $clog2(NENTRIES + 1);
   localparam int TOTAL_W1 = TOTAL_W + 1;
   localparam int KEEP_W   = (COST_BITS < tlsp_pkg::COST_FIELD_W) ?
                             COST_BITS : tlsp_pkg::COST_FIELD_W;
   localparam int SUM_W    = ((COST_BITS > DW) ? COST_BITS : DW) + 1;
   localparam int EW       = ENTRY_W + 1 + NF + COST_BITS + 1;
   localparam int SW       = STATE_W + DW;

   tlsp_pkg::state_type state_ff, state_in;

   logic [CW-1:0]       node_count_ff;
   logic [CW-1:0]       n_act;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [ENTRY_W-1:0]  head_ff [MAX_NODES];
   logic [ENTRY_W-1:0]  head_in [MAX_NODES];
   logic [MAX_NODES-1:0] head_ok_ff, head_ok_in;
   logic [NSTATES-1:0]  seen_ff, seen_in, queued_ff, queued_in;

   logic [NODE_W-1:0]   a_ff, a_in, b_ff, b_in;
   logic [COST_BITS-1:0] w_ff, w_in;
   logic                x_ff, x_in;
   logic [STATE_W-1:0]  src_ff, src_in;
   logic [NODE_W-1:0]   tgt_ff, tgt_in;
   logic [STATE_W-1:0]  scan_idx_ff, scan_idx_in, prev_ff, prev_in;
   logic                pend_ff, pend_in;
   logic                best_ok_ff, best_ok_in;
   logic [STATE_W-1:0]  best_ff, best_in;
   logic [DW-1:0]       best_dist_ff, best_dist_in;
   logic [STATE_W-1:0]  u_ff, u_in;
   logic [DW-1:0]       dist_u_ff, dist_u_in;
   logic [ENTRY_W-1:0]  e_ff, e_in;
   logic [STATE_W-1:0]  v_ff, v_in;
   logic [DW-1:0]       c_ff, c_in;
   logic [DW-1:0]       d0_ff, d0_in;
   logic [DW-1:0]       ts_dist_ff, ts_dist_in;
   logic [STATE_W-1:0]  cur_ff, cur_in;
   logic                used_ff, used_in;
   logic [NODE_W-1:0]   tnode_ff, tnode_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   tlsp_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic                   rsp_load;

   // edge memory
   logic                e_we;
   logic [ENTRY_W-1:0]  e_waddr;
   logic [EW-1:0]       e_wdata, e_rdata;
   logic                ed_x, ed_more;
   logic [COST_BITS-1:0] ed_w;
   logic [NF-1:0]       ed_dest;
   logic [ENTRY_W-1:0]  ed_next;

   // state memory
   logic                s_we;
   logic [STATE_W-1:0]  s_waddr, s_raddr;
   logic [SW-1:0]       s_wdata, s_rdata;
   logic [DW-1:0]       sd_dist;
   logic [STATE_W-1:0]  sd_par;

   logic                req_fire, out_free;
   logic [STATE_W-1:0]  last_state;
   logic [COST_BITS-1:0] req_w;
   logic                elig;
   logic [STATE_W-1:0]  v_comb;
   logic [SUM_W-1:0]    sum;
   logic [DW-1:0]       c_comb;
   logic                cand;
   logic                improve;
   logic                pick1, s0, s1;

   tlsp_ram #(.WIDTH(EW), .DEPTH(NENTRIES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_waddr),
      .wr_data (e_wdata),
      .rd_addr (e_ff),
      .rd_data (e_rdata)
   );

   tlsp_ram #(.WIDTH(SW), .DEPTH(NSTATES)) u_state_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   assign ed_x    = e_rdata[0];
   assign ed_w    = e_rdata[COST_BITS:1];
   assign ed_dest = e_rdata[COST_BITS+NF:COST_BITS+1];
   assign ed_more = e_rdata[COST_BITS+NF+1];
   assign ed_next = e_rdata[EW-1:COST_BITS+NF+2];
   assign sd_dist = s_rdata[DW-1:0];
   assign sd_par  = s_rdata[SW-1:DW];

   always_comb begin
      if (node_count_ff == '0) begin
         n_act = CW'(1);
      end else if (node_count_ff > CW'(MAX_NODES)) begin
         n_act = CW'(MAX_NODES);
      end else begin
         n_act = node_count_ff;
      end
   end

   assign last_state = {NODE_W'(n_act - CW'(1)), 1'b1};
   assign req_ready  = (state_ff == tlsp_pkg::ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_w      = COST_BITS'(req_word.edge_cost[KEEP_W-1:0]);

   // relaxation of the current adjacency entry
   assign elig   = !(u_ff[0] && ed_x) && ({1'b0, ed_dest} < n_act);
   assign v_comb = {ed_dest[NODE_W-1:0], u_ff[0] | ed_x};
   assign sum    = SUM_W'(dist_u_ff) + SUM_W'(ed_w);
   assign c_comb = (sum > SUM_W'(tlsp_pkg::DIST_MAX)) ? tlsp_pkg::DIST_MAX : sum[DW-1:0];
   assign improve = !seen_ff[v_ff] || (sd_dist > c_ff);

   assign cand = pend_ff && queued_ff[prev_ff] && (!best_ok_ff || (sd_dist < best_dist_ff));

   assign s0    = seen_ff[{tgt_ff, 1'b0}];
   assign s1    = seen_ff[{tgt_ff, 1'b1}];
   assign pick1 = s1 && (!s0 || (d0_ff > sd_dist));

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      head_in      = head_ff;
      head_ok_in   = head_ok_ff;
      seen_in      = seen_ff;
      queued_in    = queued_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      w_in         = w_ff;
      x_in         = x_ff;
      src_in       = src_ff;
      tgt_in       = tgt_ff;
      scan_idx_in  = scan_idx_ff;
      prev_in      = prev_ff;
      pend_in      = pend_ff;
      best_ok_in   = best_ok_ff;
      best_in      = best_ff;
      best_dist_in = best_dist_ff;
      u_in         = u_ff;
      dist_u_in    = dist_u_ff;
      e_in         = e_ff;
      v_in         = v_ff;
      c_in         = c_ff;
      d0_in        = d0_ff;
      ts_dist_in   = ts_dist_ff;
      cur_in       = cur_ff;
      used_in      = used_ff;
      tnode_in     = tnode_ff;
      rsp_load     = 1'b0;
      rsp_word_in  = rsp_word_ff;
      e_we         = 1'b0;
      e_waddr      = total_ff[ENTRY_W-1:0];
      e_wdata      = '0;
      s_we         = 1'b0;
      s_waddr      = v_ff;
      s_wdata      = {u_ff, c_ff};
      s_raddr      = cur_ff;

      case (state_ff)
         tlsp_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_word.kind)
                  tlsp_pkg::KIND_CLEAR: begin
                     head_ok_in = '0;
                     total_in   = '0;
                  end
                  tlsp_pkg::KIND_QUERY: begin
                     src_in = {req_word.node_a[NODE_W-1:0], 1'b0};
                     tgt_in = req_word.node_b[NODE_W-1:0];
                     if (({1'b0, req_word.node_a} < n_act) &&
                         ({1'b0, req_word.node_b} < n_act)) begin
                        seen_in   = '0;
                        queued_in = '0;
                        seen_in[{req_word.node_a[NODE_W-1:0], 1'b0}]   = 1'b1;
                        queued_in[{req_word.node_a[NODE_W-1:0], 1'b0}] = 1'b1;
                        s_we        = 1'b1;
                        s_waddr     = {req_word.node_a[NODE_W-1:0], 1'b0};
                        s_wdata     = '0;
                        scan_idx_in = '0;
                        pend_in     = 1'b0;
                        best_ok_in  = 1'b0;
                        state_in    = tlsp_pkg::ST_SCAN;
                     end else begin
                        state_in = tlsp_pkg::ST_UNREACH;
                     end
                  end
                  default: begin
                     if (({1'b0, req_word.node_a} < n_act) &&
                         ({1'b0, req_word.node_b} < n_act) &&
                         (TOTAL_W1'(total_ff) + TOTAL_W1'(2) <= TOTAL_W1'(NENTRIES))) begin
                        a_in = req_word.node_a[NODE_W-1:0];
                        b_in = req_word.node_b[NODE_W-1:0];
                        w_in = req_w;
                        x_in = (req_word.kind == tlsp_pkg::KIND_EXPRESS);
                        e_we    = 1'b1;
                        e_wdata = {head_ff[req_word.node_a[NODE_W-1:0]],
                                   head_ok_ff[req_word.node_a[NODE_W-1:0]],
                                   req_word.node_b, req_w,
                                   req_word.kind == tlsp_pkg::KIND_EXPRESS};
                        head_in[req_word.node_a[NODE_W-1:0]]    = total_ff[ENTRY_W-1:0];
                        head_ok_in[req_word.node_a[NODE_W-1:0]] = 1'b1;
                        total_in = total_ff + TOTAL_W'(1);
                        state_in = tlsp_pkg::ST_ADD2;
                     end
                  end
               endcase
            end
         end

         tlsp_pkg::ST_ADD2: begin
            // reverse entry; head of b already reflects the first push if a == b
            e_we    = 1'b1;
            e_wdata = {head_ff[b_ff], head_ok_ff[b_ff], NF'(a_ff), w_ff, x_ff};
            head_in[b_ff]    = total_ff[ENTRY_W-1:0];
            head_ok_in[b_ff] = 1'b1;
            total_in = total_ff + TOTAL_W'(1);
            state_in = tlsp_pkg::ST_IDLE;
         end

         tlsp_pkg::ST_SCAN: begin
            s_raddr = scan_idx_ff;
            if (cand) begin
               best_ok_in   = 1'b1;
               best_in      = prev_ff;
               best_dist_in = sd_dist;
            end
            pend_in = 1'b1;
            prev_in = scan_idx_ff;
            if (scan_idx_ff == last_state) begin
               state_in = tlsp_pkg::ST_SCAN_TAIL;
            end else begin
               scan_idx_in = scan_idx_ff + STATE_W'(1);
            end
         end

         tlsp_pkg::ST_SCAN_TAIL: begin
            pend_in = 1'b0;
            if (cand) begin
               u_in      = prev_ff;
               dist_u_in = sd_dist;
               state_in  = tlsp_pkg::ST_POP;
            end else if (best_ok_ff) begin
               u_in      = best_ff;
               dist_u_in = best_dist_ff;
               state_in  = tlsp_pkg::ST_POP;
            end else begin
               state_in = tlsp_pkg::ST_PICK_A;
            end
         end

         tlsp_pkg::ST_POP: begin
            queued_in[u_ff] = 1'b0;
            e_in = head_ff[u_ff[STATE_W-1:1]];
            if (head_ok_ff[u_ff[STATE_W-1:1]]) begin
               state_in = tlsp_pkg::ST_EDGE_RD;
            end else begin
               scan_idx_in = '0;
               best_ok_in  = 1'b0;
               state_in    = tlsp_pkg::ST_SCAN;
            end
         end

         tlsp_pkg::ST_EDGE_RD: begin
            state_in = tlsp_pkg::ST_EDGE_CHK;
         end

         tlsp_pkg::ST_EDGE_CHK: begin
            s_raddr = v_comb;
            v_in    = v_comb;
            c_in    = c_comb;
            if (elig) begin
               state_in = tlsp_pkg::ST_RELAX;
            end else if (ed_more) begin
               e_in     = ed_next;
               state_in = tlsp_pkg::ST_EDGE_RD;
            end else begin
               scan_idx_in = '0;
               best_ok_in  = 1'b0;
               state_in    = tlsp_pkg::ST_SCAN;
            end
         end

         tlsp_pkg::ST_RELAX: begin
            if (improve) begin
               s_we          = 1'b1;
               seen_in[v_ff]   = 1'b1;
               queued_in[v_ff] = 1'b1;
            end
            if (ed_more) begin
               e_in     = ed_next;
               state_in = tlsp_pkg::ST_EDGE_RD;
            end else begin
               scan_idx_in = '0;
               best_ok_in  = 1'b0;
               state_in    = tlsp_pkg::ST_SCAN;
            end
         end

         tlsp_pkg::ST_PICK_A: begin
            s_raddr  = {tgt_ff, 1'b0};
            state_in = tlsp_pkg::ST_PICK_B;
         end

         tlsp_pkg::ST_PICK_B: begin
            s_raddr  = {tgt_ff, 1'b1};
            d0_in    = sd_dist;
            state_in = tlsp_pkg::ST_PICK_C;
         end

         tlsp_pkg::ST_PICK_C: begin
            // layer one wins when layer zero is unseen or layer one is strictly cheaper
            if (pick1 || s0) begin
               cur_in     = {tgt_ff, pick1};
               ts_dist_in = pick1 ? sd_dist : d0_ff;
               used_in    = 1'b0;
               tnode_in   = '0;
               state_in   = tlsp_pkg::ST_WALK_RD;
            end else begin
               state_in = tlsp_pkg::ST_UNREACH;
            end
         end

         tlsp_pkg::ST_WALK_RD: begin
            state_in = tlsp_pkg::ST_WALK_EMIT;
         end

         tlsp_pkg::ST_WALK_EMIT: begin
            if (out_free) begin
               rsp_load              = 1'b1;
               rsp_word_in           = '0;
               rsp_word_in.path_node = NF'(cur_ff[STATE_W-1:1]);
               if (cur_ff == src_ff) begin
                  rsp_word_in.last_item   = 1'b1;
                  rsp_word_in.ticket_used = used_ff;
                  rsp_word_in.ticket_node = NF'(tnode_ff);
                  rsp_word_in.total_cost  = ts_dist_ff;
                  state_in = tlsp_pkg::ST_IDLE;
               end else begin
                  if (cur_ff[0] && !sd_par[0]) begin
                     used_in  = 1'b1;
                     tnode_in = cur_ff[STATE_W-1:1];
                  end
                  cur_in   = sd_par;
                  state_in = tlsp_pkg::ST_WALK_RD;
               end
            end
         end

         tlsp_pkg::ST_UNREACH: begin
            if (out_free) begin
               rsp_load                = 1'b1;
               rsp_word_in             = '0;
               rsp_word_in.last_item   = 1'b1;
               rsp_word_in.unreachable = 1'b1;
               state_in = tlsp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tlsp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tlsp_pkg::ST_IDLE;
         node_count_ff <= tlsp_pkg::COUNT_RESET;
         total_ff      <= '0;
         head_ok_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
         best_ok_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         head_ok_ff   <= head_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         best_ok_ff   <= best_ok_in;
         if (csr_we) begin
            node_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff      <= head_in;
      seen_ff      <= seen_in;
      queued_ff    <= queued_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      w_ff         <= w_in;
      x_ff         <= x_in;
      src_ff       <= src_in;
      tgt_ff       <= tgt_in;
      scan_idx_ff  <= scan_idx_in;
      prev_ff      <= prev_in;
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      u_ff         <= u_in;
      dist_u_ff    <= dist_u_in;
      e_ff         <= e_in;
      v_ff         <= v_in;
      c_ff         <= c_in;
      d0_ff        <= d0_in;
      ts_dist_ff   <= ts_dist_in;
      cur_ff       <= cur_in;
      used_ff      <= used_in;
      tnode_ff     <= tnode_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      TOTAL_W1'(total_ff) <= TOTAL_W1'(NENTRIES))
      else $error("edge count beyond storage");

   a_best_queued: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == tlsp_pkg::ST_SCAN) || (state_ff == tlsp_pkg::ST_SCAN_TAIL))
      && best_ok_ff |-> queued_ff[best_ff])
      else $error("scan minimum not queued");

   a_relax_from_seen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlsp_pkg::ST_RELAX) |-> seen_ff[u_ff])
      else $error("relaxing from an unseen state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten");

endmodule
